@@ design/ordered_list_engine_assert.svh @@
// assertion helpers shared by the list engine
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define OLE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define OLE_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/ole_pkg.sv @@
package ole_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;

  // operation codes
  localparam logic [KIND_W-1:0] K_ADD_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] K_ADD_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] K_ADD_AT   = 3'd2;
  localparam logic [KIND_W-1:0] K_DEL_HEAD = 3'd3;
  localparam logic [KIND_W-1:0] K_DEL_TAIL = 3'd4;
  localparam logic [KIND_W-1:0] K_DEL_AT   = 3'd5;
  localparam logic [KIND_W-1:0] K_GET      = 3'd6;
  localparam logic [KIND_W-1:0] K_SEARCH   = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_data;
    logic [POS_W-1:0]          position;
    logic                      found;
    logic [COUNT_W-1:0]        entry_count;
  } out_t;

endpackage

@@ design/ole_ram.sv @@
module ole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ordered_list_engine.sv @@
// Bounded ordered list of up to ole_pkg::DEPTH signed 32-bit words, packed from
// position 0 in one RAM with a single write and a single registered read port.
// One operation is in flight at a time; in_ready_o is high only while idle.
// Inserts and deletes move every entry behind the target one place, one entry
// per cycle through the RAM; at most DEPTH - 1 entries move. A get reads one
// entry; a search reads one entry per cycle from position 0 and answers with
// the position of the first hit, or once every entry is read with no match.
// Refused and empty-list operations go straight to the result. The result
// register lets a new operation start while the previous result waits on
// out_ready_i.
`include "ordered_list_engine_assert.svh"

module ordered_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ole_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ole_pkg::out_t out_data_o
);

  localparam int unsigned AW = ole_pkg::ADDR_W;
  localparam int unsigned CW = ole_pkg::CNT_W;
  // compare width for index against count
  localparam int unsigned XW = (CW > ole_pkg::INDEX_W) ? CW : ole_pkg::INDEX_W;
  localparam int unsigned PW = ole_pkg::POS_W;
  localparam int unsigned NW = ole_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_GET  = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] pa_q, pa_d;
  logic [AW-1:0] tgt_q, tgt_d;
  logic          pend_q, pend_d;
  logic [ole_pkg::VALUE_W-1:0] word_q, word_d;
  ole_pkg::out_t res_q, res_d;
  ole_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [ole_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

  logic [XW-1:0] cnt_x, idx_x, last_x, ins_at, del_at, get_at;
  logic          full, empty;

  ole_ram #(
    .WIDTH(ole_pkg::VALUE_W),
    .DEPTH(ole_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cnt_x  = XW'(cnt_q);
  assign idx_x  = XW'(in_data_i.index);
  assign last_x = cnt_x - XW'(1);
  assign full   = (cnt_q == CW'(ole_pkg::DEPTH));
  assign empty  = (cnt_q == '0);

  // clamped positions, past the end goes to the end
  always_comb begin
    case (in_data_i.kind)
      ole_pkg::K_ADD_HEAD: ins_at = '0;
      ole_pkg::K_ADD_TAIL: ins_at = cnt_x;
      default:             ins_at = (idx_x > cnt_x) ? cnt_x : idx_x;
    endcase
    case (in_data_i.kind)
      ole_pkg::K_DEL_HEAD: del_at = '0;
      ole_pkg::K_DEL_TAIL: del_at = last_x;
      default:             del_at = (idx_x > last_x) ? last_x : idx_x;
    endcase
    get_at = (idx_x > last_x) ? last_x : idx_x;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    pa_d        = pa_q;
    tgt_d       = tgt_q;
    pend_d      = 1'b0;
    word_d      = word_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = pa_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    // shared read sequencer: one entry per cycle while reads remain
    if ((state_q == S_INS || state_q == S_DEL || state_q == S_GET || state_q == S_SRCH)
        && (n_q != '0)) begin
      ram_re = 1'b1;
      pend_d = 1'b1;
      pa_d   = ptr_q;
      n_d    = n_q - CW'(1);
      ptr_d  = (state_q == S_INS) ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d  = '0;
          word_d = in_data_i.value;
          if (in_data_i.kind inside {ole_pkg::K_ADD_HEAD, ole_pkg::K_ADD_TAIL,
                                     ole_pkg::K_ADD_AT}) begin
            if (full) begin
              res_d.status = ole_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              tgt_d   = AW'(ins_at);
              n_d     = CW'(cnt_x - ins_at);
              ptr_d   = AW'(last_x);
              state_d = S_INS;
            end
          end else if (empty) begin
            res_d.status = ole_pkg::ST_EMPTY;
            state_d      = S_DONE;
          end else if (in_data_i.kind inside {ole_pkg::K_DEL_HEAD, ole_pkg::K_DEL_TAIL,
                                              ole_pkg::K_DEL_AT}) begin
            n_d     = CW'(last_x - del_at);
            ptr_d   = AW'(del_at + XW'(1));
            state_d = S_DEL;
          end else if (in_data_i.kind == ole_pkg::K_GET) begin
            n_d     = CW'(1);
            ptr_d   = AW'(get_at);
            state_d = S_GET;
          end else begin
            n_d     = cnt_q;
            ptr_d   = '0;
            state_d = S_SRCH;
          end
        end
      end
      S_INS: begin
        // entry read last cycle moves up one place
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pa_q + AW'(1);
        end else if (n_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = tgt_q;
          ram_wdata = word_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = S_DONE;
        end
      end
      S_DEL: begin
        // entry read last cycle moves down one place
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pa_q - AW'(1);
        end else if (n_q == '0) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_GET: begin
        if (pend_q) begin
          res_d.read_data = ram_rdata;
          state_d         = S_DONE;
        end
      end
      S_SRCH: begin
        if (pend_q && (ram_rdata == word_q)) begin
          res_d.found    = 1'b1;
          res_d.position = PW'(pa_q);
          state_d        = S_DONE;
        end else if (!pend_q && (n_q == '0)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = res_q;
          out_d.entry_count = NW'(cnt_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    pa_q   <= pa_d;
    tgt_q  <= tgt_d;
    word_q <= word_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OLE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(ole_pkg::DEPTH), "count above depth")
  `OLE_ASSERT_NXT(a_ins_grow, state_q == S_INS && !pend_q && n_q == '0,
                  cnt_q == $past(cnt_q) + CW'(1), "insert did not grow count")
  `OLE_ASSERT_NXT(a_del_shrink, state_q == S_DEL && !pend_q && n_q == '0,
                  cnt_q == $past(cnt_q) - CW'(1), "delete did not shrink count")
  `OLE_ASSERT_IMP(a_found_ok, out_valid_o && out_data_o.found,
                  out_data_o.status == ole_pkg::ST_OK, "search hit with bad status")

endmodule
